>>> rtl/flash_write_packetizer_defines.svh
// assertion macros for the flash write packetizer
`ifndef FLASH_WRITE_PACKETIZER_DEFINES_SVH
`define FLASH_WRITE_PACKETIZER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FWP_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWP_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FWP_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg)
`define FWP_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg)

`endif

`endif

>>> rtl/fwp_pkg.sv
// shared types, constants and command/status structs of the flash write packetizer
`default_nettype none

package fwp_pkg;

  localparam int ADDR_W     = 28;
  localparam int EXP_W      = 29;
  localparam int DATA_W     = 8;
  localparam int LEN_W      = 8;
  localparam int CNT_W      = 6;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int BPA_W      = 3;
  localparam int POL_W      = 2;
  localparam int RTYPE_W    = 3;

  localparam int MAX_FIELD_BYTES_DEF = 58;
  localparam int REGION_COUNT_DEF    = 4;

  // region register packing
  localparam int RG_START_LSB = 0;
  localparam int RG_START_MSB = 27;
  localparam int RG_END_LSB   = 28;
  localparam int RG_END_MSB   = 56;
  localparam int RG_TYPE_LSB  = 57;
  localparam int RG_TYPE_MSB  = 59;

  localparam logic [RTYPE_W-1:0] RT_UNUSED = 3'd0;
  localparam logic [RTYPE_W-1:0] RT_CONFIG = 3'd3;

  localparam logic [POL_W-1:0] POL_WRITE = 2'd0;
  localparam logic [POL_W-1:0] POL_SKIP  = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_A       = 3'd3;

  localparam logic [CNT_W-1:0]  FIELD_SIZE_RST = 6'd58;
  localparam logic [BPA_W-1:0]  BPA_RST        = 3'd1;
  localparam logic [POL_W-1:0]  POL_RST        = POL_SKIP;

  localparam logic [DATA_W-1:0] ERASE_BYTE   = 8'hFF;
  localparam logic [EXP_W-1:0]  ADDR_INVALID = 29'h1FFF_FFFF;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_HDR         = 3'd0;
  localparam kind_t KIND_DATA        = 3'd1;
  localparam kind_t KIND_PROG_DONE   = 3'd2;
  localparam kind_t KIND_REGION_ERR  = 3'd3;
  localparam kind_t KIND_PROTECT_ERR = 3'd4;

  typedef struct packed {
    logic latch_in;
    logic decode;
    logic write_byte;
    logic flush_start;
    logic emit_hdr;
    logic emit_byte;
    logic byte_last;
    logic emit_pc;
    logic emit_err;
  } fwp_cmd_t;

  typedef struct packed {
    logic op;
    logic err_now;
    logic take;
    logic pc_cond;
    logic full_after;
    logic dirty;
    logic write_open;
    logic addr_ok;
    logic byte_final;
    logic emit_ok;
  } fwp_sts_t;

endpackage

`default_nettype wire

>>> rtl/fwp_div.sv
// bit-serial divider for the packet header address
`default_nettype none

module fwp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fwp_pkg::ADDR_W-1:0] dividend,
  input  logic [fwp_pkg::BPA_W-1:0]  divisor,
  output logic [fwp_pkg::ADDR_W-1:0] quotient,
  output logic                       done
);
  import fwp_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic [ADDR_W-1:0] quo_r;
  logic [BPA_W-1:0]  rem_r;
  logic [BPA_W-1:0]  rem_nxt;
  logic [BPA_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [BPA_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, quo_r[ADDR_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    if (ge) begin
      rem_nxt = BPA_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[BPA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(ADDR_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ADDR_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

>>> rtl/fwp_ctrl.sv
// controller state machine of the flash write packetizer
`default_nettype none

module fwp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fwp_pkg::fwp_sts_t sts,
  output fwp_pkg::fwp_cmd_t cmd
);
  import fwp_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECODE = 9'b000000010,
    ST_ERR    = 9'b000000100,
    ST_WRITE  = 9'b000001000,
    ST_FLUSH  = 9'b000010000,
    ST_HDR    = 9'b000100000,
    ST_BYTES  = 9'b001000000,
    ST_PCDONE = 9'b010000000,
    ST_SPARE  = 9'b100000000
  } state_t;

  // why a flush runs: complete request, break before a write, or full packet
  typedef enum logic [1:0] {
    MODE_PC  = 2'd0,
    MODE_PRE = 2'd1,
    MODE_END = 2'd2
  } mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  state_t after_pc;

  assign after_pc = (mode_r == MODE_PRE) ? ST_WRITE : ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_PC;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.op) begin
          mode_nxt  = MODE_PC;
          state_nxt = ST_FLUSH;
        end else if (sts.err_now) begin
          state_nxt = ST_ERR;
        end else if (!sts.take) begin
          state_nxt = ST_IDLE;
        end else if (sts.pc_cond) begin
          mode_nxt  = MODE_PRE;
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_ERR: begin
        if (sts.emit_ok) begin
          cmd.emit_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd.write_byte = 1'b1;
        if (sts.full_after) begin
          mode_nxt  = MODE_END;
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.dirty) begin
          cmd.flush_start = 1'b1;
          state_nxt       = ST_HDR;
        end else begin
          state_nxt = ST_PCDONE;
        end
      end
      ST_HDR: begin
        if (sts.addr_ok && sts.emit_ok) begin
          cmd.emit_hdr = 1'b1;
          state_nxt    = ST_BYTES;
        end
      end
      ST_BYTES: begin
        if (sts.emit_ok) begin
          cmd.emit_byte = 1'b1;
          // only a full-packet flush ends the beats of its byte
          cmd.byte_last = (mode_r == MODE_END) && sts.byte_final;
          if (sts.byte_final) begin
            state_nxt = (mode_r == MODE_END) ? ST_IDLE : ST_PCDONE;
          end
        end
      end
      ST_PCDONE: begin
        if (!sts.write_open) begin
          state_nxt = after_pc;
        end else if (sts.emit_ok) begin
          cmd.emit_pc = 1'b1;
          state_nxt   = after_pc;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/fwp_dp.sv
// datapath: config registers, region check, packet buffer, output register
`default_nettype none

module fwp_dp #(
  parameter int MAX_FIELD_BYTES = fwp_pkg::MAX_FIELD_BYTES_DEF,
  parameter int REGION_COUNT    = fwp_pkg::REGION_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fwp_pkg::fwp_cmd_t              cmd,
  output fwp_pkg::fwp_sts_t              sts,
  input  logic                           in_op,
  input  logic [fwp_pkg::ADDR_W-1:0]     in_byte_address,
  input  logic [fwp_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                           in_first_of_record,
  input  logic [fwp_pkg::LEN_W-1:0]      in_record_length,
  input  logic                           cfg_valid,
  input  logic [fwp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fwp_pkg::kind_t                 out_kind,
  output logic [fwp_pkg::ADDR_W-1:0]     out_device_address,
  output logic [fwp_pkg::CNT_W-1:0]      out_byte_count,
  output logic [fwp_pkg::DATA_W-1:0]     out_value,
  output logic                           out_last
);
  import fwp_pkg::*;

  localparam int IDX_W  = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;
  localparam int FILL_W = $clog2(MAX_FIELD_BYTES + 1);
  localparam logic [CNT_W-1:0] FIELD_MAX = CNT_W'(MAX_FIELD_BYTES & ~1);
  localparam logic [CNT_W-1:0] FIELD_MIN = CNT_W'(2);

  // configuration
  logic [CNT_W-1:0]      fsize_r;
  logic [BPA_W-1:0]      bpa_r;
  logic [POL_W-1:0]      pol_r;
  logic [CFG_DATA_W-1:0] region_r [REGION_COUNT];

  // current input beat
  logic              op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic              first_r;
  logic [LEN_W-1:0]  len_r;

  // packet state
  logic [ADDR_W-1:0] start_r;
  logic [FILL_W-1:0] fill_r;
  logic              dirty_r;
  logic              wo_r;
  logic [EXP_W-1:0]  exp_r;
  logic              pad_r;
  logic              drop_r;
  kind_t             err_kind_r;

  // flush sequencing
  logic [FILL_W-1:0] cnt_r;
  logic [FILL_W-1:0] raw_r;
  logic [FILL_W-1:0] idx_r;
  logic [FILL_W-1:0] idx_inc;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] mem [MAX_FIELD_BYTES];

  // output register
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;
  kind_t             kind_nxt;
  logic [ADDR_W-1:0] addr_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [DATA_W-1:0] value_nxt;
  logic              out_emit;

  logic [CNT_W-1:0]   fs_even;
  logic [CNT_W-1:0]   eff_size;
  logic [EXP_W-1:0]   rec_end;
  logic [RTYPE_W-1:0] rtype;
  logic               rt_none;
  logic               rt_cfg;
  logic               v_drop;
  logic               v_err;
  logic [FILL_W-1:0]  base;
  logic [FILL_W-1:0]  base_inc;
  logic [ADDR_W-1:0]  div_q;
  logic               div_done;
  logic [ADDR_W-1:0]  hdr_addr;

  fwp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.flush_start),
    .dividend (start_r),
    .divisor  (bpa_r),
    .quotient (div_q),
    .done     (div_done)
  );

  // field size rounded down to even and clamped
  assign fs_even  = {fsize_r[CNT_W-1:1], 1'b0};
  assign eff_size = (fs_even < FIELD_MIN) ? FIELD_MIN :
                    (fs_even > FIELD_MAX) ? FIELD_MAX : fs_even;

  // first matching region wins, so scan from the back
  assign rec_end = {1'b0, addr_r} + EXP_W'(len_r);
  always_comb begin
    rtype = RT_UNUSED;
    for (int i = REGION_COUNT - 1; i >= 0; i--) begin
      if (region_r[i][RG_TYPE_MSB:RG_TYPE_LSB] != RT_UNUSED &&
          addr_r >= region_r[i][RG_START_MSB:RG_START_LSB] &&
          rec_end <= region_r[i][RG_END_MSB:RG_END_LSB]) begin
        rtype = region_r[i][RG_TYPE_MSB:RG_TYPE_LSB];
      end
    end
  end

  assign rt_none = rtype == RT_UNUSED;
  assign rt_cfg  = rtype == RT_CONFIG;
  assign v_drop  = rt_none || (rt_cfg && pol_r != POL_WRITE);
  assign v_err   = rt_none || (rt_cfg && pol_r != POL_WRITE && pol_r != POL_SKIP);

  assign base     = dirty_r ? fill_r : '0;
  assign base_inc = base + FILL_W'(1);
  assign idx_inc  = idx_r + FILL_W'(1);
  assign hdr_addr = (bpa_r < BPA_W'(2)) ? start_r : div_q;

  assign sts.op         = op_r;
  assign sts.err_now    = !op_r && first_r && v_err;
  assign sts.take       = !(first_r ? v_drop : drop_r);
  assign sts.pc_cond    = ((wo_r || dirty_r) && exp_r != {1'b0, addr_r}) || pad_r;
  assign sts.full_after = CNT_W'(base_inc) >= eff_size;
  assign sts.dirty      = dirty_r;
  assign sts.write_open = wo_r;
  assign sts.addr_ok    = (bpa_r < BPA_W'(2)) || div_done;
  assign sts.byte_final = idx_r == cnt_r - FILL_W'(1);
  assign sts.emit_ok    = !out_valid_r || out_ready;

  assign out_emit = cmd.emit_hdr || cmd.emit_byte || cmd.emit_pc || cmd.emit_err;

  // buffer read runs one beat ahead of the byte being shown
  assign rd_en   = cmd.emit_hdr || (cmd.emit_byte && idx_inc < raw_r);
  assign rd_addr = cmd.emit_hdr ? '0 : idx_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      mem[base[IDX_W-1:0]] <= data_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    kind_nxt  = KIND_HDR;
    addr_nxt  = '0;
    cnt_nxt   = '0;
    value_nxt = '0;
    if (cmd.emit_hdr) begin
      addr_nxt = hdr_addr;
      cnt_nxt  = CNT_W'(cnt_r);
    end else if (cmd.emit_byte) begin
      kind_nxt  = KIND_DATA;
      value_nxt = (idx_r < raw_r) ? rd_data_r : ERASE_BYTE;
    end else if (cmd.emit_pc) begin
      kind_nxt = KIND_PROG_DONE;
    end else begin
      kind_nxt = err_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r     <= FIELD_SIZE_RST;
      bpa_r       <= BPA_RST;
      pol_r       <= POL_RST;
      for (int i = 0; i < REGION_COUNT; i++) begin
        region_r[i] <= '0;
      end
      start_r     <= '0;
      fill_r      <= '0;
      dirty_r     <= 1'b0;
      wo_r        <= 1'b0;
      exp_r       <= ADDR_INVALID;
      pad_r       <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIELD_SIZE:     fsize_r <= cfg_data[CNT_W-1:0];
          CFG_BYTES_PER_ADDR: bpa_r   <= cfg_data[BPA_W-1:0];
          CFG_POLICY:         pol_r   <= cfg_data[POL_W-1:0];
          default: ;
        endcase
        for (int i = 0; i < REGION_COUNT; i++) begin
          if (cfg_index == CFG_IDX_W'(CFG_REGION_A + i)) begin
            region_r[i] <= cfg_data;
          end
        end
      end
      if (cmd.decode && !op_r && first_r) begin
        drop_r <= v_drop;
      end
      if (cmd.write_byte) begin
        if (!dirty_r) begin
          start_r <= addr_r;
        end
        fill_r  <= base_inc;
        dirty_r <= 1'b1;
        exp_r   <= {1'b0, addr_r} + EXP_W'(1);
      end
      if (cmd.flush_start) begin
        dirty_r <= 1'b0;
        wo_r    <= 1'b1;
        // odd packet gets an erase pad and forces a program complete
        if (fill_r[0]) begin
          pad_r <= 1'b1;
          exp_r <= ADDR_INVALID;
        end else begin
          exp_r <= {1'b0, start_r} + EXP_W'(fill_r);
        end
      end
      if (cmd.emit_pc) begin
        wo_r  <= 1'b0;
        exp_r <= ADDR_INVALID;
        pad_r <= 1'b0;
      end
      if (out_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= in_op;
      addr_r  <= in_byte_address;
      data_r  <= in_data_byte;
      first_r <= in_first_of_record;
      len_r   <= in_record_length;
    end
    if (cmd.decode) begin
      err_kind_r <= rt_none ? KIND_REGION_ERR : KIND_PROTECT_ERR;
    end
    if (cmd.flush_start) begin
      cnt_r <= fill_r + FILL_W'(fill_r[0]);
      raw_r <= fill_r;
    end
    if (cmd.emit_hdr) begin
      idx_r <= '0;
    end else if (cmd.emit_byte) begin
      idx_r <= idx_inc;
    end
    if (out_emit) begin
      out_kind_r  <= kind_nxt;
      out_addr_r  <= addr_nxt;
      out_cnt_r   <= cnt_nxt;
      out_value_r <= value_nxt;
      out_last_r  <= cmd.emit_pc || cmd.emit_err || cmd.byte_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_device_address = out_addr_r;
  assign out_byte_count     = out_cnt_r;
  assign out_value          = out_value_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

>>> rtl/flash_write_packetizer.sv
// top level of the flash write packetizer
//
// port group  direction  handshake            payload
// in          in         in_valid/in_ready    op, byte_address, data_byte, first_of_record,
//                                             record_length
// out         out        out_valid/out_ready  kind, device_address, byte_count, value, last
// cfg         in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a data byte that does not close a packet passes through accept, decode and buffer write.
// a flush adds a setup step, a wait on the bit-serial address divider when
// bytes_per_address is above one, then the header and data beats.
// the buffer has one write and one read port; bytes leave one per cycle unless out stalls.
// a stalled out channel holds the flush; the next byte is taken once the last beat is in
// the output register.
// rst_n is synchronous; it clears control and config, buffer contents are not cleared.
`default_nettype none
`include "flash_write_packetizer_defines.svh"

module flash_write_packetizer #(
  parameter int MAX_FIELD_BYTES = fwp_pkg::MAX_FIELD_BYTES_DEF,
  parameter int REGION_COUNT    = fwp_pkg::REGION_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [fwp_pkg::ADDR_W-1:0]     in_byte_address,
  input  logic [fwp_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                           in_first_of_record,
  input  logic [fwp_pkg::LEN_W-1:0]      in_record_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fwp_pkg::KIND_W-1:0]     out_kind,
  output logic [fwp_pkg::ADDR_W-1:0]     out_device_address,
  output logic [fwp_pkg::CNT_W-1:0]      out_byte_count,
  output logic [fwp_pkg::DATA_W-1:0]     out_value,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fwp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fwp_pkg::*;

  fwp_cmd_t cmd;
  fwp_sts_t sts;

  assign cfg_ready = 1'b1;

  fwp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwp_dp #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
    .REGION_COUNT    (REGION_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_byte_address    (in_byte_address),
    .in_data_byte       (in_data_byte),
    .in_first_of_record (in_first_of_record),
    .in_record_length   (in_record_length),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_device_address (out_device_address),
    .out_byte_count     (out_byte_count),
    .out_value          (out_value),
    .out_last           (out_last)
  );

  `FWP_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "byte taken while previous one in work")
  `FWP_ASSERT_IMP(a_hdr_count, clk, rst_n, out_valid && out_kind == KIND_HDR, out_byte_count != '0 && !out_byte_count[0] && !out_last, "bad packet header beat")
  `FWP_ASSERT_IMP(a_side_fields, clk, rst_n, out_valid && out_kind != KIND_HDR, out_device_address == '0 && out_byte_count == '0, "header fields set on non-header beat")
  `FWP_ASSERT_IMP(a_value_field, clk, rst_n, out_valid && out_kind != KIND_DATA, out_value == '0, "value set on non-data beat")

endmodule

`default_nettype wire
